// ===== rtl/core/tsfm_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package tsfm_pkg;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int TIME_BITS_DEF   = 32;

    localparam logic [2:0] CFG_THRESH   = 3'd0;
    localparam logic [2:0] CFG_CALIB_X  = 3'd1;
    localparam logic [2:0] CFG_CALIB_Y  = 3'd2;
    localparam logic [2:0] CFG_ORIENT   = 3'd3;
    localparam logic [2:0] CFG_WIDTH    = 3'd4;
    localparam logic [2:0] CFG_HEIGHT   = 3'd5;
    localparam logic [2:0] CFG_INTERVAL = 3'd6;

    localparam logic [1:0] EV_NONE    = 2'd0;
    localparam logic [1:0] EV_TOUCH   = 2'd1;
    localparam logic [1:0] EV_RELEASE = 2'd2;

    // controller to datapath
    typedef struct packed {
        logic load;
        logic div_start;
        logic div_sel_y;
        logic div_norm;
        logic norm_done;
        logic finish;
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic touch;
        logic div_busy;
    } t_status;
endpackage
`default_nettype wire

// ===== rtl/core/tsfm_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsfm_div
    import tsfm_pkg::*;
#(
    parameter int W = 26
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_start,
    input  wire logic [W-1:0] i_num,
    input  wire logic [W-1:0] i_den,
    output logic              o_busy,
    output logic [W-1:0]      o_quo
);
    localparam int CW = $clog2(W + 1);

    logic [W-1:0]  r_quo, n_quo;
    logic [W-1:0]  r_rem, n_rem;
    logic [W-1:0]  r_den;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [W:0]    w_shift;

    // one quotient bit per cycle, restoring
    always_comb begin
        n_quo   = r_quo;
        n_rem   = r_rem;
        n_cnt   = r_cnt;
        w_shift = {r_rem, r_quo[W-1]};
        if (i_start) begin
            n_quo = i_num;
            n_rem = '0;
            n_cnt = CW'(W);
        end else if (r_cnt != '0) begin
            if (w_shift >= {1'b0, r_den}) begin
                n_rem = W'(w_shift - {1'b0, r_den});
                n_quo = {r_quo[W-2:0], 1'b1};
            end else begin
                n_rem = w_shift[W-1:0];
                n_quo = {r_quo[W-2:0], 1'b0};
            end
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        if (i_start) begin
            r_den <= i_den;
        end
    end

    assign o_busy = (r_cnt != '0);
    assign o_quo  = r_quo;
endmodule
`default_nettype wire

// ===== rtl/core/tsfm_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsfm_ctrl
    import tsfm_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_take,
    input  wire logic i_out_busy,
    input  t_status   i_status,
    output t_cmd      o_cmd,
    output logic      o_idle
);
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LOAD  = 3'd1;
    localparam logic [2:0] S_NX    = 3'd2;
    localparam logic [2:0] S_NY    = 3'd3;
    localparam logic [2:0] S_SX    = 3'd4;
    localparam logic [2:0] S_SY    = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0] r_state, n_state;
    logic       r_wait, n_wait;

    // sequence: normalize x, y, then scale x, y; each step starts, then waits until not busy; no touch skips to done
    always_comb begin
        n_state = r_state;
        n_wait  = r_wait;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_take) n_state = S_LOAD;
            end
            S_LOAD: begin
                o_cmd.load = 1'b1;
                n_state    = S_NX;
                n_wait     = 1'b0;
            end
            S_NX, S_NY, S_SX, S_SY: begin
                o_cmd.div_sel_y = (r_state == S_NY) || (r_state == S_SY);
                o_cmd.div_norm  = (r_state == S_NX) || (r_state == S_NY);
                if (!i_status.touch) begin
                    n_state = S_DONE;
                end else if (!r_wait) begin
                    o_cmd.div_start = 1'b1;
                    n_wait = 1'b1;
                end else if (!i_status.div_busy) begin
                    n_wait = 1'b0;
                    o_cmd.norm_done = 1'b1;
                    n_state = r_state + 3'd1;
                end
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_wait  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_wait  <= n_wait;
        end
    end

    assign o_idle = (r_state == S_IDLE);
endmodule
`default_nettype wire

// ===== rtl/core/tsfm_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none
module tsfm_dp
    import tsfm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  t_cmd                        i_cmd,
    output t_status                     o_status,
    input  wire logic [SAMPLE_BITS-1:0] i_p1,
    input  wire logic [SAMPLE_BITS-1:0] i_p2,
    input  wire logic [SAMPLE_BITS-1:0] i_xa,
    input  wire logic [SAMPLE_BITS-1:0] i_xb,
    input  wire logic [SAMPLE_BITS-1:0] i_xc,
    input  wire logic [SAMPLE_BITS-1:0] i_ya,
    input  wire logic [SAMPLE_BITS-1:0] i_yb,
    input  wire logic [SAMPLE_BITS-1:0] i_yc,
    input  wire logic [TIME_BITS-1:0]   i_now,
    input  wire logic [SAMPLE_BITS:0]   i_thresh,
    input  wire logic [2*SAMPLE_BITS-1:0] i_calib_x,
    input  wire logic [2*SAMPLE_BITS-1:0] i_calib_y,
    input  wire logic [4:0]             i_orient,
    input  wire logic [11:0]            i_width,
    input  wire logic [11:0]            i_height,
    input  wire logic [TIME_BITS-1:0]   i_interval,
    output logic [1:0]                  o_event,
    output logic [11:0]                 o_pos_x,
    output logic [11:0]                 o_pos_y,
    output logic [SAMPLE_BITS:0]        o_pressure,
    output logic [SAMPLE_BITS-1:0]      o_raw_x,
    output logic [SAMPLE_BITS-1:0]      o_raw_y
);
    localparam int SB = SAMPLE_BITS;
    localparam int DW = (2 * SB + 1 > SB + 12) ? 2 * SB + 1 : SB + 12;
    localparam logic [SB-1:0] FS = {SB{1'b1}};

    function automatic logic [SB-1:0] best_two(input logic [SB-1:0] a,
        input logic [SB-1:0] b, input logic [SB-1:0] c);
        logic [SB-1:0] dab, dac, dbc;
        logic [SB:0]   s;
        dab = (a > b) ? a - b : b - a;
        dac = (a > c) ? a - c : c - a;
        dbc = (b > c) ? b - c : c - b;
        if (dab <= dac && dab <= dbc)      s = {1'b0, a} + {1'b0, b};
        else if (dac <= dbc)               s = {1'b0, a} + {1'b0, c};
        else                               s = {1'b0, b} + {1'b0, c};
        return s[SB:1];
    endfunction

    logic [SB:0]    r_z;
    logic           r_touch;
    logic [SB-1:0]  r_rx, r_ry, r_nx, r_ny;
    logic [TIME_BITS-1:0] r_now, r_last_time;
    logic           r_flag;
    logic [11:0]    r_lpx, r_lpy;
    logic [11:0]    r_px, r_py;
    logic [SB:0]    w_z;

    assign w_z = {1'b0, i_p1} + {1'b0, FS} - {1'b0, i_p2};

    // capture the sample set and the front-end filtering
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_z     <= w_z;
            r_touch <= (w_z >= i_thresh);
            r_rx    <= best_two(i_xa, i_xb, i_xc);
            r_ry    <= best_two(i_ya, i_yb, i_yc);
            r_now   <= i_now;
        end
    end

    // normalize operand selection
    logic [SB-1:0] w_v, w_lo, w_hi;
    logic          w_deg;
    logic [SB-1:0] w_sat;
    assign w_v   = i_cmd.div_sel_y ? r_ry : r_rx;
    assign w_lo  = i_cmd.div_sel_y ? i_calib_y[SB-1:0] : i_calib_x[SB-1:0];
    assign w_hi  = i_cmd.div_sel_y ? i_calib_y[2*SB-1:SB] : i_calib_x[2*SB-1:SB];
    assign w_deg = (w_v <= w_lo) || (w_v >= w_hi);
    assign w_sat = (w_v <= w_lo) ? '0 : FS;

    // orientation applied to normalized pair
    logic [SB-1:0] w_ox, w_oy, w_t;
    always_comb begin
        w_ox = r_nx;
        w_oy = r_ny;
        if (i_orient[0]) begin w_t = w_ox; w_ox = w_oy; w_oy = w_t; end
        else w_t = w_ox;
        if (i_orient[1]) w_ox = FS - w_ox;
        if (i_orient[2]) w_oy = FS - w_oy;
        case (i_orient[4:3])
            2'd1: begin w_t = w_ox; w_ox = w_oy; w_oy = FS - w_t; end
            2'd2: begin w_ox = FS - w_ox; w_oy = FS - w_oy; end
            2'd3: begin w_t = w_ox; w_ox = FS - w_oy; w_oy = w_t; end
            default: ;
        endcase
    end

    // divider operands
    logic [DW-1:0] w_num, w_den, w_quo;
    logic          w_busy;
    always_comb begin
        if (i_cmd.div_norm) begin
            w_num = DW'(FS) * DW'(w_v - w_lo);
            w_den = DW'(w_hi - w_lo);
        end else begin
            w_num = i_cmd.div_sel_y ? DW'(w_oy) * DW'(i_height)
                                    : DW'(w_ox) * DW'(i_width);
            w_den = DW'(FS);
        end
    end

    tsfm_div #(.W(DW)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.div_start && i_cmd.div_norm),
        .i_num   (w_num),
        .i_den   (w_den),
        .o_busy  (w_busy),
        .o_quo   (w_quo)
    );

    // scale by full scale: product registered, then fold and one correction step
    logic [DW-1:0] r_snum;
    logic [DW:0]   w_fold;
    logic [DW-1:0] w_q1, w_r, w_sq;
    always_ff @(posedge i_clk) begin
        if (i_cmd.div_start && !i_cmd.div_norm) begin
            r_snum <= w_num;
        end
    end

    always_comb begin
        w_fold = {1'b0, r_snum} + (DW+1)'(r_snum >> SB) + (DW+1)'(r_snum >> (2 * SB))
                 + (DW+1)'(1);
        w_q1   = DW'(w_fold >> SB);
        w_r    = r_snum - ((w_q1 << SB) - w_q1);
        w_sq   = (w_r >= DW'(FS)) ? w_q1 + DW'(1) : w_q1;
    end

    // divide results
    always_ff @(posedge i_clk) begin
        if (i_cmd.norm_done) begin
            if (i_cmd.div_norm) begin
                if (i_cmd.div_sel_y) r_ny <= w_deg ? w_sat : w_quo[SB-1:0];
                else                 r_nx <= w_deg ? w_sat : w_quo[SB-1:0];
            end else begin
                if (i_cmd.div_sel_y) r_py <= w_sq[11:0];
                else                 r_px <= w_sq[11:0];
            end
        end
    end

    // event decision and state
    logic w_report;
    assign w_report = !r_flag || ((r_now - r_last_time) >= i_interval);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag      <= 1'b0;
            r_last_time <= '0;
            r_lpx       <= '0;
            r_lpy       <= '0;
        end else if (i_cmd.finish) begin
            if (r_touch) begin
                if (w_report) begin
                    r_flag <= 1'b1;
                    r_last_time <= r_now;
                    r_lpx <= r_px;
                    r_lpy <= r_py;
                end
            end else begin
                r_flag <= 1'b0;
            end
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_touch) begin
                o_event    <= w_report ? EV_TOUCH : EV_NONE;
                o_pos_x    <= r_px;
                o_pos_y    <= r_py;
                o_pressure <= r_z;
                o_raw_x    <= r_rx;
                o_raw_y    <= r_ry;
            end else begin
                o_event    <= r_flag ? EV_RELEASE : EV_NONE;
                o_pos_x    <= r_lpx;
                o_pos_y    <= r_lpy;
                o_pressure <= '0;
                o_raw_x    <= '0;
                o_raw_y    <= '0;
            end
        end
    end

    assign o_status.touch    = r_touch;
    assign o_status.div_busy = w_busy;
endmodule
`default_nettype wire

// ===== rtl/core/touch_sample_filter_mapper_core.sv =====
`timescale 1ns / 1ps
`default_nettype none
// channel | direction | handshake           | payload
// input   | in        | i_in_valid/o_in_stall  | pressures, x/y samples, now_ms
// result  | out       | o_out_valid/i_out_stall| event, positions, pressure, raw
// config  | in        | i_cfg_valid/o_cfg_ready| i_cfg_index, i_cfg_data
// a touched item passes through load, two normalize divides through one radix-2
// divider, two full-scale scale steps, then finish and idle; an untouched item
// skips the divides and goes from load to finish. one item in flight; the next
// item is taken while a result waits, and its result holds in the finish state
// until the waiting one is taken.
// synchronous active-low reset restores register defaults and clears touch state.
module touch_sample_filter_mapper_core
    import tsfm_pkg::*;
#(
    parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_in_valid,
    output logic                        o_in_stall,
    input  wire logic [SAMPLE_BITS-1:0] i_pressure_one,
    input  wire logic [SAMPLE_BITS-1:0] i_pressure_two,
    input  wire logic [SAMPLE_BITS-1:0] i_x_sample_a,
    input  wire logic [SAMPLE_BITS-1:0] i_x_sample_b,
    input  wire logic [SAMPLE_BITS-1:0] i_x_sample_c,
    input  wire logic [SAMPLE_BITS-1:0] i_y_sample_a,
    input  wire logic [SAMPLE_BITS-1:0] i_y_sample_b,
    input  wire logic [SAMPLE_BITS-1:0] i_y_sample_c,
    input  wire logic [TIME_BITS-1:0]   i_now_ms,
    output logic                        o_out_valid,
    input  wire logic                   i_out_stall,
    output logic [1:0]                  o_event_res,
    output logic [11:0]                 o_pos_x,
    output logic [11:0]                 o_pos_y,
    output logic [SAMPLE_BITS:0]        o_pressure,
    output logic [SAMPLE_BITS-1:0]      o_raw_x,
    output logic [SAMPLE_BITS-1:0]      o_raw_y,
    input  wire logic                   i_cfg_valid,
    output logic                        o_cfg_ready,
    input  wire logic [2:0]             i_cfg_index,
    input  wire logic [31:0]            i_cfg_data
);
    localparam int SB = SAMPLE_BITS;

    logic [SB:0]        r_thresh;
    logic [2*SB-1:0]    r_calib_x, r_calib_y;
    logic [4:0]         r_orient;
    logic [11:0]        r_width, r_height;
    logic [TIME_BITS-1:0] r_interval;
    logic               r_out_valid;
    t_cmd               w_cmd;
    t_status            w_status;
    logic               w_idle, w_take;

    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh   <= (SB+1)'(400);
            r_calib_x  <= {{SB{1'b1}}, {SB{1'b0}}};
            r_calib_y  <= {{SB{1'b1}}, {SB{1'b0}}};
            r_orient   <= '0;
            r_width    <= 12'd320;
            r_height   <= 12'd240;
            r_interval <= TIME_BITS'(50);
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_THRESH:   r_thresh   <= (SB+1)'(i_cfg_data);
                CFG_CALIB_X:  r_calib_x  <= (2*SB)'(i_cfg_data);
                CFG_CALIB_Y:  r_calib_y  <= (2*SB)'(i_cfg_data);
                CFG_ORIENT:   r_orient   <= i_cfg_data[4:0];
                CFG_WIDTH:    r_width    <= i_cfg_data[11:0];
                CFG_HEIGHT:   r_height   <= i_cfg_data[11:0];
                CFG_INTERVAL: r_interval <= TIME_BITS'(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_in_stall = !w_idle;
    assign w_take     = i_in_valid && w_idle;

    // result valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end
    assign o_out_valid = r_out_valid;

    tsfm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_take  (w_take),
        .i_out_busy (r_out_valid && i_out_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd),
        .o_idle     (w_idle)
    );

    // input item is registered on accept and captured into the datapath by load in the next cycle
    logic [SB-1:0] r_p1, r_p2, r_xa, r_xb, r_xc, r_ya, r_yb, r_yc;
    logic [TIME_BITS-1:0] r_now;
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_p1 <= i_pressure_one; r_p2 <= i_pressure_two;
            r_xa <= i_x_sample_a; r_xb <= i_x_sample_b; r_xc <= i_x_sample_c;
            r_ya <= i_y_sample_a; r_yb <= i_y_sample_b; r_yc <= i_y_sample_c;
            r_now <= i_now_ms;
        end
    end

    tsfm_dp #(.SAMPLE_BITS(SAMPLE_BITS), .TIME_BITS(TIME_BITS)) u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (w_cmd),
        .o_status   (w_status),
        .i_p1       (r_p1),
        .i_p2       (r_p2),
        .i_xa       (r_xa),
        .i_xb       (r_xb),
        .i_xc       (r_xc),
        .i_ya       (r_ya),
        .i_yb       (r_yb),
        .i_yc       (r_yc),
        .i_now      (r_now),
        .i_thresh   (r_thresh),
        .i_calib_x  (r_calib_x),
        .i_calib_y  (r_calib_y),
        .i_orient   (r_orient),
        .i_width    (r_width),
        .i_height   (r_height),
        .i_interval (r_interval),
        .o_event    (o_event_res),
        .o_pos_x    (o_pos_x),
        .o_pos_y    (o_pos_y),
        .o_pressure (o_pressure),
        .o_raw_x    (o_raw_x),
        .o_raw_y    (o_raw_y)
    );
endmodule
`default_nettype wire

// ===== sim/tb_touch_sample_filter_mapper_core.sv =====
`timescale 1ns / 1ps
module tb_touch_sample_filter_mapper_core;
    import tsfm_pkg::*;

    localparam logic [11:0] FULL = 12'hfff;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam int RANDOM_ITEMS = 1800;

    typedef struct packed {
        logic [11:0] p1;
        logic [11:0] p2;
        logic [11:0] xa;
        logic [11:0] xb;
        logic [11:0] xc;
        logic [11:0] ya;
        logic [11:0] yb;
        logic [11:0] yc;
        logic [31:0] now;
    } t_sample_set;

    typedef struct packed {
        logic [1:0]  ev;
        logic [11:0] px;
        logic [11:0] py;
        logic [12:0] pz;
        logic [11:0] rx;
        logic [11:0] ry;
    } t_touch_result;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    t_sample_set in_item;
    logic        out_valid;
    logic        out_stall;
    logic [1:0]  ev_res;
    logic [11:0] pos_x, pos_y, raw_x, raw_y;
    logic [12:0] pres;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    // shadow configuration and touch state
    logic [12:0] m_thresh;
    logic [23:0] m_calx, m_caly;
    logic [4:0]  m_orient;
    logic [11:0] m_width, m_height;
    logic [31:0] m_interval;
    logic        m_touched;
    logic [31:0] m_last_time;
    logic [11:0] m_last_x, m_last_y;

    t_sample_set   pending_sets[$];
    t_touch_result expected_results[$];
    int mismatches;
    int idle_cycles;
    bit timed_out;
    int gap_left, burst_left;
    int stall_phase;

    touch_sample_filter_mapper_core dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_pressure_one(in_item.p1), .i_pressure_two(in_item.p2),
        .i_x_sample_a(in_item.xa), .i_x_sample_b(in_item.xb),
        .i_x_sample_c(in_item.xc),
        .i_y_sample_a(in_item.ya), .i_y_sample_b(in_item.yb),
        .i_y_sample_c(in_item.yc),
        .i_now_ms(in_item.now),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_event_res(ev_res), .o_pos_x(pos_x), .o_pos_y(pos_y),
        .o_pressure(pres), .o_raw_x(raw_x), .o_raw_y(raw_y),
        .i_cfg_valid(cfg_valid), .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic logic [11:0] best_two_mean(logic [11:0] a, logic [11:0] b,
                                                  logic [11:0] c);
        int dab, dac, dbc;
        dab = (a > b) ? a - b : b - a;
        dac = (a > c) ? a - c : c - a;
        dbc = (b > c) ? b - c : c - b;
        if (dab <= dac && dab <= dbc) return 12'((13'(a) + 13'(b)) >> 1);
        if (dac <= dab && dac <= dbc) return 12'((13'(a) + 13'(c)) >> 1);
        return 12'((13'(b) + 13'(c)) >> 1);
    endfunction

    function automatic logic [11:0] normalize(logic [11:0] v, logic [23:0] calib);
        logic [11:0] lo, hi;
        lo = calib[11:0];
        hi = calib[23:12];
        if (v <= lo) return 12'd0;
        if (v >= hi) return FULL;
        return 12'((32'(FULL) * 32'(v - lo)) / 32'(hi - lo));
    endfunction

    // advance the shadow state by one sample set and queue its result
    task automatic predict_touch(input t_sample_set s);
        t_touch_result r;
        logic [12:0] z;
        logic [11:0] x, y, t;
        z = 13'(s.p1) + 13'(FULL) - 13'(s.p2);
        r = '0;
        r.ev = EV_NONE;
        r.px = m_last_x;
        r.py = m_last_y;
        if (z >= m_thresh) begin
            r.rx = best_two_mean(s.xa, s.xb, s.xc);
            r.ry = best_two_mean(s.ya, s.yb, s.yc);
            r.pz = z;
            x = normalize(r.rx, m_calx);
            y = normalize(r.ry, m_caly);
            if (m_orient[0]) begin t = x; x = y; y = t; end
            if (m_orient[1]) x = FULL - x;
            if (m_orient[2]) y = FULL - y;
            case (m_orient[4:3])
                2'd1: begin t = x; x = y; y = FULL - t; end
                2'd2: begin x = FULL - x; y = FULL - y; end
                2'd3: begin t = x; x = FULL - y; y = t; end
                default: ;
            endcase
            r.px = 12'((32'(x) * 32'(m_width)) / 32'(FULL));
            r.py = 12'((32'(y) * 32'(m_height)) / 32'(FULL));
            if (!m_touched || (s.now - m_last_time) >= m_interval) begin
                r.ev = EV_TOUCH;
                m_last_x = r.px;
                m_last_y = r.py;
                m_touched = 1'b1;
                m_last_time = s.now;
            end
        end else if (m_touched) begin
            r.ev = EV_RELEASE;
            m_touched = 1'b0;
        end
        expected_results.push_back(r);
    endtask

    // input driver: bursts and gaps, payload held while stalled
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            gap_left <= 0;
            burst_left <= 0;
        end else if (!in_valid || !in_stall) begin
            if (in_valid) predict_touch(in_item);
            if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                in_valid <= 1'b0;
            end else if (pending_sets.size() > 0) begin
                in_item <= pending_sets.pop_front();
                in_valid <= 1'b1;
                if (burst_left == 0) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 150);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result monitor and stall pattern
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            stall_phase <= 0;
            idle_cycles <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            case ((stall_phase / 2000) % 3)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 3) == 0);
                default: out_stall <= (stall_phase % 7) < 4;
            endcase
            // watchdog on cycles with no handshake at all
            if ((in_valid && !in_stall) || (cfg_valid && cfg_ready) ||
                (out_valid && !out_stall)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
                if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1'b1;
            end
            if (out_valid && !out_stall) begin
                if (expected_results.size() == 0) begin
                    mismatches <= mismatches + 1;
                    if (mismatches < 10) $display("unexpected result event %0d", ev_res);
                end else begin
                    t_touch_result e;
                    e = expected_results.pop_front();
                    if (e != {ev_res, pos_x, pos_y, pres, raw_x, raw_y}) begin
                        mismatches <= mismatches + 1;
                        if (mismatches < 10)
                            $display("mismatch exp ev=%0d x=%0d y=%0d p=%0d rx=%0d ry=%0d",
                                e.ev, e.px, e.py, e.pz, e.rx, e.ry,
                                " | got ev=%0d x=%0d y=%0d p=%0d rx=%0d ry=%0d",
                                ev_res, pos_x, pos_y, pres, raw_x, raw_y);
                    end
                end
            end
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            CFG_THRESH:   m_thresh = val[12:0];
            CFG_CALIB_X:  m_calx = val[23:0];
            CFG_CALIB_Y:  m_caly = val[23:0];
            CFG_ORIENT:   m_orient = val[4:0];
            CFG_WIDTH:    m_width = val[11:0];
            CFG_HEIGHT:   m_height = val[11:0];
            CFG_INTERVAL: m_interval = val;
            default: ;
        endcase
    endtask

    // wait on settled values until nothing is pending or in flight
    task automatic drain;
        while (pending_sets.size() > 0 || in_valid || expected_results.size() > 0)
            @(negedge clk);
        repeat (150) @(posedge clk);
    endtask

    function automatic t_sample_set random_set(int mode, logic [31:0] t);
        t_sample_set s;
        s = t_sample_set'({$urandom, $urandom, $urandom, $urandom, $urandom});
        s.now = t;
        if (mode == 0) begin
            // firm press with clustered samples
            s.p1 = 12'($urandom_range(1000, 4095));
            s.p2 = 12'($urandom_range(0, 2000));
            s.xb = 12'(s.xa + 12'($urandom_range(0, 40)));
            s.yc = 12'(s.ya - 12'($urandom_range(0, 40)));
        end else if (mode == 1) begin
            // lifted
            s.p1 = 12'($urandom_range(0, 100));
            s.p2 = 12'($urandom_range(3900, 4095));
        end
        return s;
    endfunction

    function automatic logic [23:0] random_calib();
        logic [11:0] lo, hi;
        lo = 12'($urandom_range(0, 1500));
        hi = 12'($urandom_range(2500, 4095));
        case ($urandom_range(0, 5))
            0: return {hi, lo};
            1: return {lo, hi};
            2: return {lo, lo};
            default: return 24'($urandom);
        endcase
    endfunction

    initial begin
        t_sample_set s;
        logic [31:0] clock_ms;
        int phase;
        in_valid = 1'b0;
        in_item = '0;
        cfg_valid = 1'b0;
        cfg_index = CFG_THRESH;
        cfg_data = '0;
        out_stall = 1'b0;
        mismatches = 0;
        timed_out = 1'b0;
        m_thresh = 13'd400;
        m_calx = 24'd16773120;
        m_caly = 24'd16773120;
        m_orient = 5'd0;
        m_width = 12'd320;
        m_height = 12'd240;
        m_interval = 32'd50;
        m_touched = 1'b0;
        m_last_time = '0;
        m_last_x = '0;
        m_last_y = '0;
        rst_n = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: default setup, extremes, ties, release, wrap
        pending_sets.push_back('{12'd0, FULL, 0, 0, 0, 0, 0, 0, 32'd0});
        pending_sets.push_back('{FULL, 12'd0, FULL, FULL, FULL, FULL, FULL, FULL, 32'd1});
        pending_sets.push_back('{FULL, 12'd0, 12'd100, 12'd110, 12'd120, 12'd10, 12'd20,
                                 12'd30, 32'd2});
        pending_sets.push_back('{FULL, 12'd0, 12'd100, 12'd90, 12'd110, 12'd50, 12'd60,
                                 12'd70, 32'd60});
        pending_sets.push_back('{12'd0, FULL, 0, 0, 0, 0, 0, 0, 32'd61});
        pending_sets.push_back('{12'd0, FULL, 0, 0, 0, 0, 0, 0, 32'd62});
        pending_sets.push_back('{FULL, 12'd0, 12'd0, 12'd4000, FULL, FULL, 12'd0,
                                 12'd2000, 32'hffff_fff0});
        pending_sets.push_back('{FULL, 12'd0, 12'd2000, 12'd2000, 12'd2000, 12'd1, 12'd1,
                                 12'd3, 32'd40});
        pending_sets.push_back('{12'd0, 12'd0, 12'h555, 12'haaa, 12'h800, 12'h7ff,
                                 12'h123, 12'hedc, 32'hffff_ffff});
        drain();
        write_reg(CFG_THRESH, 32'd0);
        write_reg(CFG_INTERVAL, 32'd0);
        write_reg(CFG_CALIB_X, {12'd3000, 12'd1000});
        write_reg(CFG_CALIB_Y, {12'd500, 12'd500});
        write_reg(CFG_ORIENT, 32'd31);
        write_reg(CFG_WIDTH, 32'd4095);
        write_reg(CFG_HEIGHT, 32'd0);
        pending_sets.push_back('{12'd0, FULL, 12'd999, 12'd1000, 12'd1001, 12'd499,
                                 12'd500, 12'd501, 32'd5});
        pending_sets.push_back('{12'd0, FULL, 12'd2000, 12'd2001, 12'd0, FULL, FULL,
                                 12'd0, 32'd5});
        pending_sets.push_back('{FULL, 12'd0, 12'd3000, 12'd3001, 12'd2999, 12'd0, 12'd0,
                                 12'd0, 32'd5});
        drain();
        write_reg(CFG_THRESH, 32'd8190);
        write_reg(CFG_INTERVAL, 32'hffff_ffff);
        pending_sets.push_back('{FULL, 12'd0, 0, 0, 0, 0, 0, 0, 32'd7});
        pending_sets.push_back('{FULL, 12'd1, 0, 0, 0, 0, 0, 0, 32'd8});
        drain();

        // random phases over several configurations
        clock_ms = $urandom;
        for (phase = 0; phase < 12; phase++) begin
            write_reg(CFG_THRESH, (phase % 4 == 0) ? 32'd0 : $urandom_range(0, 5000));
            write_reg(CFG_CALIB_X, random_calib());
            write_reg(CFG_CALIB_Y, random_calib());
            write_reg(CFG_ORIENT, $urandom_range(0, 31));
            write_reg(CFG_WIDTH, (phase == 3) ? 32'd1 : $urandom_range(1, 4095));
            write_reg(CFG_HEIGHT, (phase == 5) ? 32'd4095 : $urandom_range(1, 4095));
            write_reg(CFG_INTERVAL, (phase == 7) ? $urandom : $urandom_range(0, 80));
            repeat (RANDOM_ITEMS / 12) begin
                clock_ms = clock_ms + $urandom_range(0, 40);
                s = random_set(($urandom_range(0, 9) < 6) ? 0 :
                               ($urandom_range(0, 1) ? 1 : 2), clock_ms);
                pending_sets.push_back(s);
            end
            drain();
        end

        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // watchdog on a stalled run
    initial begin
        wait (timed_out);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end
endmodule

// ===== touch_sample_filter_mapper_core.f =====
rtl/core/tsfm_pkg.sv
rtl/core/tsfm_div.sv
rtl/core/tsfm_ctrl.sv
rtl/core/tsfm_dp.sv
rtl/core/touch_sample_filter_mapper_core.sv
sim/tb_touch_sample_filter_mapper_core.sv
